/* hdl/lzsd_pkg.sv */
// Shared constants and types of the LZSS stream decoder.
package lzsd_pkg;

	localparam int WINDOW_SIZE_DEF = 4096;
	localparam int BYTE_W = 8;
	localparam int LEN_W = 16;
	localparam int DIST_W = 12;
	localparam int COUNT_W = 5;
	localparam int HIST_DEPTH = 17;
	localparam int HIST_IDX_W = 5;
	localparam logic [COUNT_W-1:0] MIN_MATCH = COUNT_W'(3);
	localparam logic [3:0] LEN_MASK = 4'hF;
	localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;

	// Side information that travels with one window read of a copy.
	typedef struct packed {
		logic fwd;
		logic zero;
		logic last;
		logic [HIST_IDX_W-1:0] hsel;
	} copy_tag_t;

endpackage

/* hdl/lzss_stream_decoder_unit.sv */
// Top level of the LZSS stream decoder with a history window in block RAM.
//
// This block decodes an LZSS stream one compressed byte per input transfer and
// emits the decompressed bytes as output transfers, one per cycle at best, with
// out_last marking the final byte caused by each input byte. A write of
// stream_length on the configuration channel restarts decoding: the window reads
// as zeros again and the next byte is a flag byte. The window itself is not swept
// clean; a fill count tells which entries were written since the restart, and any
// entry beyond it reads as zero. Flag bytes, the first byte of a reference,
// ignored bytes past the stream length and references of distance zero produce
// nothing. A literal produces one byte. A reference of N bytes (3 to 18) streams
// out one byte per cycle while the output is not stalled, through the single
// read port of the window RAM, so the second reference byte holds off the next
// input transfer until the last byte of the copy has moved on. Copies that
// overlap their own output take the repeated bytes from a short history of the
// bytes just produced instead of the RAM. An output register decouples the
// result side: a stalled result holds the copy in place and blocks new input
// transfers until it moves.
module lzss_stream_decoder_unit
	import lzsd_pkg::*;
#(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [BYTE_W-1:0] in_byte,
	output logic out_valid,
	input  logic out_stall,
	output logic [BYTE_W-1:0] out_byte,
	output logic out_last,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [LEN_W-1:0] stream_length
);

	localparam int AW = $clog2(WINDOW_SIZE);
	localparam logic [AW:0] WIN_EXT = (AW+1)'(WINDOW_SIZE);
	localparam logic [AW-1:0] WIN_LAST = AW'(WINDOW_SIZE - 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_COPY = 1'b1;

	localparam logic [1:0] PH_FLAG = 2'd0;
	localparam logic [1:0] PH_DATA = 2'd1;
	localparam logic [1:0] PH_SECOND = 2'd2;

	// Control state.
	logic state_q;
	logic [1:0] phase_q;
	logic [BYTE_W-1:0] flag_bits_q;
	logic [3:0] flags_left_q;
	logic [BYTE_W-1:0] held_q;
	logic [LEN_W-1:0] consumed_q;
	logic [LEN_W-1:0] length_q;
	logic [AW-1:0] wp_q;
	logic [AW:0] fill_q;

	// Copy sequencer.
	logic [AW-1:0] src_q;
	logic [DIST_W-1:0] dist_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] issued_q;
	logic [BYTE_W-1:0] hist_q [HIST_DEPTH];

	// Read stage: a window read is in flight or waiting for the output register.
	logic v_s1;
	copy_tag_t tag_s1;

	// Output register.
	logic out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic out_last_q;

	logic out_free;
	logic accept;
	logic cfg_wr;
	logic active;
	logic is_ref_first;
	logic lit_wr;
	logic start_copy;
	logic issue;
	logic s1_move;
	logic copy_done;
	logic [BYTE_W-1:0] res_byte;
	logic [BYTE_W-1:0] rd_data;
	logic wr_en;
	logic [BYTE_W-1:0] wr_data;
	logic [DIST_W-1:0] new_dist;
	logic [COUNT_W-1:0] new_count;
	logic [AW:0] rp_ext;
	logic [3:0] left_dec;
	logic [AW-1:0] wp_inc;
	logic [AW-1:0] src_inc;
	copy_tag_t tag_new;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign cfg_ready = (state_q == ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign cfg_wr = cfg_valid && cfg_ready;

	assign active = consumed_q < length_q;
	// A zero flag starts a reference only while at least two bytes remain.
	assign is_ref_first = !flag_bits_q[0]
		&& (({1'b0, consumed_q} + 17'd1) < {1'b0, length_q});
	assign lit_wr = accept && active && (phase_q == PH_DATA) && !is_ref_first;

	assign new_dist = {in_byte, held_q[7:4]};
	assign new_count = {1'b0, held_q[3:0] & LEN_MASK} + MIN_MATCH;
	assign start_copy = accept && active && (phase_q == PH_SECOND) && (new_dist != '0);

	// Start of the copy source, modulo the window size.
	always_comb begin
		if ({1'b0, wp_q} >= (AW+1)'(new_dist)) begin
			rp_ext = {1'b0, wp_q} - (AW+1)'(new_dist);
		end else begin
			rp_ext = {1'b0, wp_q} + WIN_EXT - (AW+1)'(new_dist);
		end
	end

	assign left_dec = flags_left_q - 4'd1;
	assign wp_inc = (wp_q == WIN_LAST) ? '0 : wp_q + AW'(1);
	assign src_inc = (src_q == WIN_LAST) ? '0 : src_q + AW'(1);

	assign s1_move = v_s1 && out_free;
	assign issue = (state_q == ST_COPY) && (issued_q != count_q) && (!v_s1 || out_free);
	assign copy_done = (state_q == ST_COPY) && (issued_q == count_q) && (!v_s1 || s1_move);

	// Bytes at or beyond the distance repeat bytes of this same copy.
	always_comb begin
		tag_new.fwd = ({7'd0, issued_q} >= dist_q);
		tag_new.zero = !({1'b0, src_q} < fill_q);
		tag_new.last = ((issued_q + COUNT_W'(1)) == count_q);
		tag_new.hsel = dist_q[HIST_IDX_W-1:0] - HIST_IDX_W'(1);
	end

	always_comb begin
		if (tag_s1.fwd) begin
			res_byte = hist_q[tag_s1.hsel];
		end else if (tag_s1.zero) begin
			res_byte = '0;
		end else begin
			res_byte = rd_data;
		end
	end

	assign wr_en = lit_wr || s1_move;
	assign wr_data = lit_wr ? in_byte : res_byte;

	lzsd_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(WINDOW_SIZE)
	) u_window (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wp_q),
		.wr_data(wr_data),
		.rd_en(issue),
		.rd_addr(src_q),
		.rd_data(rd_data)
	);

	// Decoder control, window position and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_FLAG;
			flag_bits_q <= '0;
			flags_left_q <= '0;
			held_q <= '0;
			consumed_q <= '0;
			length_q <= '0;
			wp_q <= '0;
			fill_q <= '0;
			issued_q <= '0;
			v_s1 <= 1'b0;
		end else if (cfg_wr) begin
			state_q <= ST_IDLE;
			phase_q <= PH_FLAG;
			flag_bits_q <= '0;
			flags_left_q <= '0;
			held_q <= '0;
			consumed_q <= '0;
			length_q <= stream_length;
			wp_q <= '0;
			fill_q <= '0;
			issued_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			if (accept && active) begin
				consumed_q <= consumed_q + LEN_W'(1);
				case (phase_q)
					PH_FLAG: begin
						flag_bits_q <= in_byte;
						flags_left_q <= FLAGS_PER_BYTE;
						phase_q <= PH_DATA;
					end
					PH_DATA: begin
						if (is_ref_first) begin
							held_q <= in_byte;
							phase_q <= PH_SECOND;
						end else begin
							flag_bits_q <= flag_bits_q >> 1;
							flags_left_q <= left_dec;
							phase_q <= (left_dec == '0) ? PH_FLAG : PH_DATA;
						end
					end
					default: begin
						flag_bits_q <= flag_bits_q >> 1;
						flags_left_q <= left_dec;
						phase_q <= (left_dec == '0) ? PH_FLAG : PH_DATA;
					end
				endcase
			end
			if (start_copy) begin
				state_q <= ST_COPY;
				issued_q <= '0;
			end else if (copy_done) begin
				state_q <= ST_IDLE;
			end
			if (issue) begin
				issued_q <= issued_q + COUNT_W'(1);
				v_s1 <= 1'b1;
			end else if (s1_move) begin
				v_s1 <= 1'b0;
			end
			if (wr_en) begin
				wp_q <= wp_inc;
				if (fill_q != WIN_EXT) begin
					fill_q <= fill_q + (AW+1)'(1);
				end
			end
		end
	end

	// Copy parameters, read tags and the short history of produced bytes.
	always_ff @(posedge clk) begin
		if (start_copy) begin
			src_q <= rp_ext[AW-1:0];
			dist_q <= new_dist;
			count_q <= new_count;
		end else if (issue) begin
			src_q <= src_inc;
		end
		if (issue) begin
			tag_s1 <= tag_new;
		end
		if (s1_move) begin
			hist_q[0] <= res_byte;
			for (int i = 1; i < HIST_DEPTH; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cfg_wr) begin
			out_valid_q <= 1'b0;
		end else if (wr_en) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			out_byte_q <= wr_data;
			out_last_q <= lit_wr ? 1'b1 : tag_s1.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

endmodule

/* hdl/lzsd_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module lzsd_ram
	import lzsd_pkg::*;
#(
	parameter int WIDTH = BYTE_W,
	parameter int DEPTH = WINDOW_SIZE_DEF
) (
	input  logic clk,
	input  logic wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
